/* design/wavelet_coef_parent_map_core_assert.svh */
// Assertion macros used by the checker module of the parent-map core.
// No dependencies; include by bare file name.
`ifndef WAVELET_COEF_PARENT_MAP_CORE_ASSERT_SVH
`define WAVELET_COEF_PARENT_MAP_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define WCPM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define WCPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/wcpm_pkg.sv */
// Types, constants and band-size function for the wavelet parent-map core.
// No dependencies.
package wcpm_pkg;

  localparam int unsigned CFG_DIM_W = 13;
  localparam int unsigned CFG_LVL_W = 4;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned IDX_W     = 24;
  localparam int unsigned SB_W      = 2;
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned DATA_W    = 32;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_LEVELS = 2'd2;

  localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = 13'd512;
  localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = 13'd512;
  localparam logic [CFG_LVL_W-1:0] LEVELS_RST = 4'd5;

  localparam logic [SB_W-1:0] SB_LL = 2'd0;
  localparam logic [SB_W-1:0] SB_HL = 2'd1;
  localparam logic [SB_W-1:0] SB_LH = 2'd2;
  localparam logic [SB_W-1:0] SB_HH = 2'd3;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] width;
    logic [CFG_DIM_W-1:0] height;
    logic [CFG_LVL_W-1:0] levels;
  } cfg_t;

  // size after k ceiling halvings: ceil(dim / 2^k)
  function automatic logic [CFG_DIM_W-1:0] band_size(input logic [CFG_DIM_W-1:0] dim,
                                                     input logic [4:0] k);
    logic [30:0] sum;
    sum = 31'(dim) + (31'(1) << k) - 31'(1);
    return CFG_DIM_W'(sum >> k);
  endfunction

endpackage

/* design/wcpm_regs.sv */
// APB-style configuration registers of the wavelet parent-map core.
// Depends on wcpm_pkg.
module wcpm_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wcpm_pkg::ADDR_W-1:0]   paddr,
  input  logic [wcpm_pkg::DATA_W-1:0]   pwdata,
  output logic [wcpm_pkg::DATA_W-1:0]   prdata,
  output wcpm_pkg::cfg_t                cfg
);

  logic       wr;
  logic [1:0] sel;

  assign wr  = psel && penable && pwrite;
  assign sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= wcpm_pkg::WIDTH_RST;
      cfg.height <= wcpm_pkg::HEIGHT_RST;
      cfg.levels <= wcpm_pkg::LEVELS_RST;
    end else if (wr) begin
      case (sel)
        wcpm_pkg::REG_WIDTH:  cfg.width  <= pwdata[wcpm_pkg::CFG_DIM_W-1:0];
        wcpm_pkg::REG_HEIGHT: cfg.height <= pwdata[wcpm_pkg::CFG_DIM_W-1:0];
        wcpm_pkg::REG_LEVELS: cfg.levels <= pwdata[wcpm_pkg::CFG_LVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      wcpm_pkg::REG_WIDTH:  prdata = wcpm_pkg::DATA_W'(cfg.width);
      wcpm_pkg::REG_HEIGHT: prdata = wcpm_pkg::DATA_W'(cfg.height);
      wcpm_pkg::REG_LEVELS: prdata = wcpm_pkg::DATA_W'(cfg.levels);
      default:              prdata = '0;
    endcase
  end

endmodule

/* design/wavelet_coef_parent_map_core.sv */
// Wavelet coefficient parent map: level, subband, parent index and order key.
// Depends on wcpm_pkg and wcpm_regs.
// Throughput: one beat per cycle while no finished beat waits under out_stall.
// Stages: band compares per level, level encode, parent coords, index multiply-add.
// The whole pipe holds while a finished beat waits under out_stall.
// Reset clears all valid bits and sets width 512, height 512, levels 5.
module wavelet_coef_parent_map_core #(
  parameter int MAX_LEVELS = 12,
  parameter int MAX_DIM    = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wcpm_pkg::ADDR_W-1:0]    paddr,
  input  logic [wcpm_pkg::DATA_W-1:0]    pwdata,
  output logic [wcpm_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [wcpm_pkg::POS_W-1:0]     pos_x,
  input  logic [wcpm_pkg::POS_W-1:0]     pos_y,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [wcpm_pkg::CFG_LVL_W-1:0] level,
  output logic [wcpm_pkg::SB_W-1:0]      subband,
  output logic                           parent_valid,
  output logic [wcpm_pkg::IDX_W-1:0]     parent_index,
  output logic [wcpm_pkg::CFG_LVL_W-1:0] order_key
);

  localparam int DW = wcpm_pkg::CFG_DIM_W;
  localparam int LW = wcpm_pkg::CFG_LVL_W;
  localparam int PW = wcpm_pkg::POS_W;
  localparam int DIM_CAP = (MAX_DIM > 8191) ? 8191 : MAX_DIM;
  localparam int LVL_CAP = (MAX_LEVELS > 15) ? 15 : MAX_LEVELS;

  wcpm_pkg::cfg_t cfg;

  wcpm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  logic [DW-1:0] w_c;
  logic [DW-1:0] h_c;
  logic [LW-1:0] nl_c;

  assign w_c  = (cfg.width  > DW'(DIM_CAP)) ? DW'(DIM_CAP) : cfg.width;
  assign h_c  = (cfg.height > DW'(DIM_CAP)) ? DW'(DIM_CAP) : cfg.height;
  assign nl_c = (cfg.levels > LW'(LVL_CAP)) ? LW'(LVL_CAP) : cfg.levels;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  // stage 1: per-level inside tests
  logic                  s1_v;
  logic [PW-1:0]         s1_x;
  logic [PW-1:0]         s1_y;
  logic                  s1_inplane;
  logic [MAX_LEVELS-1:0] s1_inside;
  logic [MAX_LEVELS-1:0] inside_next;

  always_comb begin
    for (int k = 1; k <= MAX_LEVELS; k++) begin
      inside_next[k-1] =
        ({1'b0, pos_x} < wcpm_pkg::band_size(w_c, 5'(k))) &&
        ({1'b0, pos_y} < wcpm_pkg::band_size(h_c, 5'(k)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x       <= pos_x;
      s1_y       <= pos_y;
      s1_inplane <= ({1'b0, pos_x} < w_c) && ({1'b0, pos_y} < h_c);
      s1_inside  <= inside_next;
    end
  end

  // stage 2: level encode and band sizes at that level
  logic          s2_v;
  logic [PW-1:0] s2_x;
  logic [PW-1:0] s2_y;
  logic          s2_inplane;
  logic [LW-1:0] s2_lev;
  logic [DW-1:0] s2_bwl;
  logic [DW-1:0] s2_bwp;
  logic [DW-1:0] s2_bhl;
  logic [DW-1:0] s2_bhp;
  logic [LW-1:0] lev_next;

  always_comb begin
    lev_next = '0;
    for (int k = MAX_LEVELS; k >= 1; k--) begin
      if (5'(k) <= {1'b0, nl_c} && !s1_inside[k-1]) begin
        lev_next = LW'(k);
      end
    end
    if (!s1_inplane) begin
      lev_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_x       <= s1_x;
      s2_y       <= s1_y;
      s2_inplane <= s1_inplane;
      s2_lev     <= lev_next;
      s2_bwl     <= wcpm_pkg::band_size(w_c, 5'(lev_next));
      s2_bwp     <= wcpm_pkg::band_size(w_c, 5'(lev_next) + 5'd1);
      s2_bhl     <= wcpm_pkg::band_size(h_c, 5'(lev_next));
      s2_bhp     <= wcpm_pkg::band_size(h_c, 5'(lev_next) + 5'd1);
    end
  end

  // stage 3: subband, parent coordinates, parent check
  logic                          s3_v;
  logic [LW-1:0]                 s3_lev;
  logic [wcpm_pkg::SB_W-1:0]     s3_sb;
  logic [LW-1:0]                 s3_key;
  logic                          s3_pv;
  logic [DW-1:0]                 s3_px;
  logic [DW-1:0]                 s3_py;
  logic                          right;
  logic                          bottom;
  logic [wcpm_pkg::SB_W-1:0]     sb_next;
  logic [DW-1:0]                 px_next;
  logic [DW-1:0]                 py_next;
  logic                          pv_next;
  logic [LW-1:0]                 key_next;

  always_comb begin
    right  = ({1'b0, s2_x} >= s2_bwl);
    bottom = ({1'b0, s2_y} >= s2_bhl);
    if (s2_lev == '0) begin
      sb_next = wcpm_pkg::SB_LL;
    end else if (right && !bottom) begin
      sb_next = wcpm_pkg::SB_HL;
    end else if (!right && bottom) begin
      sb_next = wcpm_pkg::SB_LH;
    end else begin
      sb_next = wcpm_pkg::SB_HH;
    end
    if (s2_lev != '0 && right) begin
      px_next = s2_bwp + (({1'b0, s2_x} - s2_bwl) >> 1);
    end else begin
      px_next = DW'(s2_x >> 1);
    end
    if (s2_lev != '0 && bottom) begin
      py_next = s2_bhp + (({1'b0, s2_y} - s2_bhl) >> 1);
    end else begin
      py_next = DW'(s2_y >> 1);
    end
    if (s2_lev == '0) begin
      pv_next  = s2_inplane && (nl_c != '0) && (px_next < s2_bwp) && (py_next < s2_bhp);
      key_next = '0;
    end else begin
      pv_next  = s2_inplane && (s2_lev < nl_c) && (px_next < w_c) && (py_next < h_c);
      key_next = nl_c - s2_lev + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_lev <= s2_lev;
      s3_sb  <= sb_next;
      s3_key <= key_next;
      s3_pv  <= pv_next;
      s3_px  <= px_next;
      s3_py  <= py_next;
    end
  end

  // stage 4: row * width + column, output register
  logic [2*DW-1:0] prod;
  logic [2*DW-1:0] idx_sum;

  assign prod    = s3_py * w_c;
  assign idx_sum = prod + (2*DW)'(s3_px);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      level        <= s3_lev;
      subband      <= s3_sb;
      order_key    <= s3_key;
      parent_valid <= s3_pv;
      parent_index <= s3_pv ? idx_sum[wcpm_pkg::IDX_W-1:0] : '0;
    end
  end

endmodule

/* design/wcpm_checker.sv */
// Port-level checks for the wavelet parent-map core, bound to the top level.
// Depends on wcpm_pkg and wavelet_coef_parent_map_core_assert.svh.
`include "wavelet_coef_parent_map_core_assert.svh"

module wcpm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [wcpm_pkg::CFG_LVL_W-1:0] level,
  input logic [wcpm_pkg::SB_W-1:0]      subband,
  input logic                           parent_valid,
  input logic [wcpm_pkg::IDX_W-1:0]     parent_index,
  input logic [wcpm_pkg::CFG_LVL_W-1:0] order_key
);

  `WCPM_ASSERT_NOW(a_no_parent_zero, clk, rst, out_valid && !parent_valid, parent_index == '0)
  `WCPM_ASSERT_NOW(a_ll_level, clk, rst, out_valid,
                   (level == '0) == (subband == wcpm_pkg::SB_LL))
  `WCPM_ASSERT_NOW(a_ll_key, clk, rst, out_valid && level == '0, order_key == '0)
  `WCPM_ASSERT_NOW(a_stall_back, clk, rst, out_valid && out_stall, in_stall)
  `WCPM_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall,
                    out_valid && $stable(level) && $stable(parent_index))

endmodule

bind wavelet_coef_parent_map_core wcpm_checker u_wcpm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .level        (level),
  .subband      (subband),
  .parent_valid (parent_valid),
  .parent_index (parent_index),
  .order_key    (order_key)
);
